FILE: hdl/gtthm_pkg.sv
// ----------------------------------------------------------------------------
// gtthm_pkg
// Shared types and constants of the gate truth-table hash map: codes,
// table geometry, and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package gtthm_pkg;

  // Table geometry
  localparam int TABLE_SIZE    = 256;
  localparam int SLOT_BITS     = $clog2(TABLE_SIZE);
  localparam int PAIRS_PER_KEY = 8;
  localparam int PAIR_BITS     = $clog2(PAIRS_PER_KEY);
  localparam int CNT_W         = PAIR_BITS + 1;
  localparam int VAR_BITS      = 20;
  localparam int KEY_W         = VAR_BITS + 1;
  localparam int TT_W          = 16;
  localparam int LIT_W         = 21;
  localparam int KC_W          = SLOT_BITS;

  // Slot row: four key variables and the pair count
  localparam int SLOT_W = 4 * KEY_W + CNT_W;
  // Pair row: truth table and literal
  localparam int PAIR_W = TT_W + LIT_W;

  localparam logic [KEY_W-1:0] NO_VAR       = '1;
  localparam logic [31:0]      HASH_SEED    = 32'hd33421da;
  localparam logic [7:0]       MAX_KEYS_RST = 8'd192;

  typedef enum logic [1:0] {
    OP_FIND  = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    LIT_ZERO = 2'd0,
    LIT_IN   = 2'd1,
    LIT_PAIR = 2'd2
  } lit_src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_HASH,
    S_FINAL,
    S_PROBE,
    S_PCMP,
    S_PAIR,
    S_PCHK,
    S_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic     load_item;
    logic     clear;
    logic     hash_step;
    logic     hash_final;
    logic     probe_rd;
    logic     slot_next;
    logic     pair_init;
    logic     pair_rd;
    logic     pair_next;
    logic     wr_new;
    logic     wr_add;
    logic     res_load;
    status_e  res_st;
    lit_src_e res_src;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op;
    logic used_s;
    logic key_match;
    logic probe_last;
    logic hash_last;
    logic p_at_n;
    logic n_full;
    logic tt_hit;
    logic room;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/gate_truth_table_hash_map_top.sv
// ----------------------------------------------------------------------------
// gate_truth_table_hash_map_top
// Deduplicating gate table: find / get / clear of (key, truth table) items
// over a linear-probing slot table with a short pair list per key.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   opcode .. literal_in
//   out      output     out_valid_o / out_stall_i status, literal_out
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_max_keys_i
//
// One item at a time. Find/get hash the key, probe the occupied slots
// and read the key's pair rows; clear and unused opcode go straight to
// the result. The cost is set by the registered reads of the slot and
// pair memories, one read per probe step, and by four hash rounds.
// Reset clears the occupancy bits and key count at once; no clearing pass.
// A stalled result sits in the output register; the next item is taken
// meanwhile and waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module gate_truth_table_hash_map_top
  import gtthm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       opcode_i,
  input  logic             table_form_i,
  input  logic [2:0]       var_count_i,
  input  logic [KEY_W-1:0] key_var0_i,
  input  logic [KEY_W-1:0] key_var1_i,
  input  logic [KEY_W-1:0] key_var2_i,
  input  logic [KEY_W-1:0] key_var3_i,
  input  logic [TT_W-1:0]  truth_table_i,
  input  logic [LIT_W-1:0] literal_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [LIT_W-1:0] literal_out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_max_keys_i
);

  cmd_t cmd;
  sts_t sts;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  gtthm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gtthm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_max_keys_i(cfg_max_keys_i),
    .opcode_i      (opcode_i),
    .table_form_i  (table_form_i),
    .var_count_i   (var_count_i),
    .key_var0_i    (key_var0_i),
    .key_var1_i    (key_var1_i),
    .key_var2_i    (key_var2_i),
    .key_var3_i    (key_var3_i),
    .truth_table_i (truth_table_i),
    .literal_in_i  (literal_in_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .literal_out_o (literal_out_o)
  );

endmodule

FILE: hdl/gtthm_ram.sv
// ----------------------------------------------------------------------------
// gtthm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gtthm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/gtthm_ctrl.sv
// ----------------------------------------------------------------------------
// gtthm_ctrl
// Sequencer: hash rounds, linear probe over slots, scan of the key's pair
// list, insert and result hand-off.
// ----------------------------------------------------------------------------
module gtthm_ctrl
  import gtthm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e   state_q, state_d;
  status_e  res_st_q, res_st_d;
  lit_src_e res_src_q, res_src_d;

  // state and pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_st_q  <= ST_MISS;
      res_src_q <= LIT_ZERO;
    end else begin
      state_q   <= state_d;
      res_st_q  <= res_st_d;
      res_src_q <= res_src_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d   = state_q;
    res_st_d  = res_st_q;
    res_src_d = res_src_q;
    cmd_o     = '0;
    cmd_o.res_st  = res_st_q;
    cmd_o.res_src = res_src_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            res_st_d  = ST_HIT;
            res_src_d = LIT_ZERO;
            state_d   = S_RESP;
          end
          OP_NONE: begin
            res_st_d  = ST_MISS;
            res_src_d = LIT_ZERO;
            state_d   = S_RESP;
          end
          default: state_d = S_HASH;
        endcase
      end
      S_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd_o.hash_final = 1'b1;
        state_d = S_PROBE;
      end
      S_PROBE: begin
        if (!sts_i.used_s) begin
          // free slot: key absent
          state_d   = S_RESP;
          res_src_d = LIT_ZERO;
          if (sts_i.op == OP_FIND) begin
            res_st_d = ST_MISS;
          end else if (!sts_i.room) begin
            res_st_d = ST_FULL;
          end else begin
            cmd_o.wr_new = 1'b1;
            res_st_d  = ST_INSERTED;
            res_src_d = LIT_IN;
          end
        end else begin
          cmd_o.probe_rd = 1'b1;
          state_d = S_PCMP;
        end
      end
      S_PCMP: begin
        if (sts_i.key_match) begin
          cmd_o.pair_init = 1'b1;
          state_d = S_PAIR;
        end else if (sts_i.probe_last) begin
          // every slot probed, none free
          res_st_d  = (sts_i.op == OP_FIND) ? ST_MISS : ST_FULL;
          res_src_d = LIT_ZERO;
          state_d   = S_RESP;
        end else begin
          cmd_o.slot_next = 1'b1;
          state_d = S_PROBE;
        end
      end
      S_PAIR: begin
        if (sts_i.p_at_n) begin
          state_d   = S_RESP;
          res_src_d = LIT_ZERO;
          if (sts_i.op == OP_FIND) begin
            res_st_d = ST_MISS;
          end else if (sts_i.n_full) begin
            res_st_d = ST_FULL;
          end else begin
            cmd_o.wr_add = 1'b1;
            res_st_d  = ST_INSERTED;
            res_src_d = LIT_IN;
          end
        end else begin
          cmd_o.pair_rd = 1'b1;
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        if (sts_i.tt_hit) begin
          res_st_d  = ST_HIT;
          res_src_d = LIT_PAIR;
          state_d   = S_RESP;
        end else begin
          cmd_o.pair_next = 1'b1;
          state_d = S_PAIR;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/gtthm_dpath.sv
// ----------------------------------------------------------------------------
// gtthm_dpath
// Datapath: item registers and table normalization, hash unit, slot and
// pair memories, occupancy bits, key count and output register.
// ----------------------------------------------------------------------------
module gtthm_dpath
  import gtthm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_max_keys_i,
  input  logic [1:0]       opcode_i,
  input  logic             table_form_i,
  input  logic [2:0]       var_count_i,
  input  logic [KEY_W-1:0] key_var0_i,
  input  logic [KEY_W-1:0] key_var1_i,
  input  logic [KEY_W-1:0] key_var2_i,
  input  logic [KEY_W-1:0] key_var3_i,
  input  logic [TT_W-1:0]  truth_table_i,
  input  logic [LIT_W-1:0] literal_in_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [1:0]       status_o,
  output logic [LIT_W-1:0] literal_out_o
);

  // three-variable table: each bit doubled
  function automatic logic [TT_W-1:0] dbl_tt(input logic [7:0] t);
    logic [TT_W-1:0] o;
    for (int i = 0; i < 8; i++) begin
      o[2*i]   = t[i];
      o[2*i+1] = t[i];
    end
    return o;
  endfunction

  // wide table: row x0+2x1+4x2+8x3 goes to bit 8x0+4x1+2x2+x3
  function automatic logic [TT_W-1:0] wide_tt(input logic [TT_W-1:0] t,
                                               input logic [2:0] n);
    logic [TT_W-1:0] o;
    logic [3:0]      jv;
    logic [3:0]      row;
    for (int j = 0; j < TT_W; j++) begin
      jv  = 4'(j);
      row = '0;
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < n) row[k] = jv[3-k];
      end
      o[j] = t[row];
    end
    return o;
  endfunction

  op_e              op_q;
  logic [KEY_W-1:0] key_q [4];
  logic [TT_W-1:0]  tt_q;
  logic [LIT_W-1:0] lit_q;
  logic [31:0]      h_q;
  logic [1:0]       rnd_q;
  logic [SLOT_BITS-1:0] s_q;
  logic [SLOT_BITS-1:0] pcnt_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] p_q;
  logic [TABLE_SIZE-1:0] used_q;
  logic [KC_W-1:0]  key_count_q;
  logic [7:0]       max_keys_q;
  logic             out_valid_q;
  status_e          status_q;
  logic [LIT_W-1:0] lit_out_q;

  logic [2:0]       nv;
  logic [KEY_W-1:0] key_in [4];
  logic [TT_W-1:0]  tt_in;

  // normalize the incoming key and table
  always_comb begin
    nv = (var_count_i > 3'd4) ? 3'd4 : var_count_i;
    key_in[0] = key_var0_i;
    key_in[1] = key_var1_i;
    key_in[2] = key_var2_i;
    key_in[3] = key_var3_i;
    if (!table_form_i) begin
      key_in[3] = NO_VAR;
      tt_in     = dbl_tt(truth_table_i[7:0]);
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) >= nv) key_in[i] = NO_VAR;
      end
      tt_in = wide_tt(truth_table_i, nv);
    end
  end

  // item registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NONE;
    end else if (cmd_i.load_item) begin
      op_q <= op_e'(opcode_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      for (int i = 0; i < 4; i++) key_q[i] <= key_in[i];
      tt_q  <= tt_in;
      lit_q <= literal_in_i;
    end
  end

  // hash: one mixing round per cycle, then the final avalanche
  logic [31:0] h1, h2, h3, f1, f2, f3;
  always_comb begin
    h1 = h_q + 32'(key_q[rnd_q]);
    h2 = h1 + (h1 << 10);
    h3 = h2 ^ (h2 >> 6);
    f1 = h_q + (h_q << 3);
    f2 = f1 ^ (f1 >> 11);
    f3 = f2 + (f2 << 15);
  end

  // slot memory: key and pair count per slot
  logic                 slot_we;
  logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
  logic [CNT_W-1:0]     slot_cnt;
  logic                 key_match;

  assign slot_we    = cmd_i.wr_new | cmd_i.wr_add;
  assign slot_wdata = {key_q[0], key_q[1], key_q[2], key_q[3],
                       cmd_i.wr_new ? CNT_W'(1) : n_q + CNT_W'(1)};
  assign slot_cnt   = slot_rdata[CNT_W-1:0];
  assign key_match  = (slot_rdata[SLOT_W-1 -: KEY_W]           == key_q[0]) &&
                      (slot_rdata[SLOT_W-1-KEY_W -: KEY_W]     == key_q[1]) &&
                      (slot_rdata[SLOT_W-1-2*KEY_W -: KEY_W]   == key_q[2]) &&
                      (slot_rdata[SLOT_W-1-3*KEY_W -: KEY_W]   == key_q[3]);

  gtthm_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TABLE_SIZE)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(s_q),
    .wdata_i(slot_wdata),
    .re_i   (cmd_i.probe_rd),
    .raddr_i(s_q),
    .rdata_o(slot_rdata)
  );

  // pair memory: rows of a slot's list
  logic [SLOT_BITS+PAIR_BITS-1:0] pair_waddr, pair_raddr;
  logic [PAIR_W-1:0]              pair_rdata;
  logic [TT_W-1:0]                pair_tt;
  logic [LIT_W-1:0]               pair_lit;

  assign pair_waddr = {s_q, cmd_i.wr_new ? PAIR_BITS'(0) : n_q[PAIR_BITS-1:0]};
  assign pair_raddr = {s_q, p_q[PAIR_BITS-1:0]};
  assign pair_tt    = pair_rdata[PAIR_W-1 -: TT_W];
  assign pair_lit   = pair_rdata[LIT_W-1:0];

  gtthm_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(TABLE_SIZE * PAIRS_PER_KEY)
  ) u_pair_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(pair_waddr),
    .wdata_i({tt_q, lit_q}),
    .re_i   (cmd_i.pair_rd),
    .raddr_i(pair_raddr),
    .rdata_o(pair_rdata)
  );

  // hash, probe and pair-scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= HASH_SEED;
      rnd_q  <= '0;
      s_q    <= '0;
      pcnt_q <= '0;
      n_q    <= '0;
      p_q    <= '0;
    end else begin
      if (cmd_i.load_item) begin
        h_q   <= HASH_SEED;
        rnd_q <= '0;
      end else if (cmd_i.hash_step) begin
        h_q   <= h3;
        rnd_q <= rnd_q + 2'd1;
      end
      if (cmd_i.hash_final) begin
        s_q    <= f3[SLOT_BITS-1:0];
        pcnt_q <= '0;
      end else if (cmd_i.slot_next) begin
        s_q    <= s_q + 1'b1;
        pcnt_q <= pcnt_q + 1'b1;
      end
      if (cmd_i.pair_init) begin
        n_q <= (slot_cnt > CNT_W'(PAIRS_PER_KEY)) ? CNT_W'(PAIRS_PER_KEY) : slot_cnt;
        p_q <= '0;
      end else if (cmd_i.pair_next) begin
        p_q <= p_q + CNT_W'(1);
      end
    end
  end

  // occupancy bits and key count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      key_count_q <= '0;
    end else if (cmd_i.clear) begin
      used_q      <= '0;
      key_count_q <= '0;
    end else if (cmd_i.wr_new) begin
      used_q[s_q] <= 1'b1;
      key_count_q <= key_count_q + 1'b1;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_keys_q <= MAX_KEYS_RST;
    end else if (cfg_we_i) begin
      max_keys_q <= cfg_max_keys_i;
    end
  end

  // output register
  logic             out_free;
  logic [LIT_W-1:0] res_lit;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (cmd_i.res_src)
      LIT_IN:   res_lit = lit_q;
      LIT_PAIR: res_lit = (pair_tt == tt_q) ? pair_lit : pair_lit ^ LIT_W'(1);
      default:  res_lit = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q  <= cmd_i.res_st;
      lit_out_q <= res_lit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign literal_out_o = lit_out_q;

  // status to controller
  always_comb begin
    sts_o.op         = op_q;
    sts_o.used_s     = used_q[s_q];
    sts_o.key_match  = key_match;
    sts_o.probe_last = (pcnt_q == SLOT_BITS'(TABLE_SIZE - 1));
    sts_o.hash_last  = (rnd_q == 2'd3);
    sts_o.p_at_n     = (p_q == n_q);
    sts_o.n_full     = (n_q >= CNT_W'(PAIRS_PER_KEY));
    sts_o.tt_hit     = (pair_tt == tt_q) || (pair_tt == ~tt_q);
    sts_o.room       = (key_count_q < max_keys_q) &&
                       (key_count_q != KC_W'(TABLE_SIZE - 1));
    sts_o.out_free   = out_free;
  end

  // occupied slots always match the key count
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(key_count_q))
    else $error("key count out of step with occupied slots");

  // a result is only loaded when the output register can take it
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> out_free)
    else $error("result overwrote a pending item");

  // a new key only goes into a free slot
  a_newslot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |-> !used_q[s_q])
    else $error("insert into an occupied slot");

  // a pair is appended only below the list limit
  a_pairroom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_add |=> (n_q < CNT_W'(PAIRS_PER_KEY)))
    else $error("pair list overrun");

endmodule

FILE: tb/sv/gate_truth_table_hash_map_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_truth_table_hash_map_top_tb
// Self-checking bench for the gate truth-table hash map. A local model of
// the slot table and pair lists predicts status and literal for each item.
// The run covers directed corner items, then random phases under several
// key limits, with random gaps on the input side and random output stalls.
// ----------------------------------------------------------------------------
module gate_truth_table_hash_map_top_tb;
  import gtthm_pkg::*;

  typedef struct packed {
    op_e              op;
    logic             form;
    logic [2:0]       nv;
    logic [KEY_W-1:0] k0, k1, k2, k3;
    logic [TT_W-1:0]  tt;
    logic [LIT_W-1:0] lit;
  } gate_item_t;

  typedef struct packed {
    status_e          st;
    logic [LIT_W-1:0] lit;
  } gate_answer_t;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // DUT inputs, all known from time zero
  logic             in_valid = 1'b0;
  logic [1:0]       opcode = '0;
  logic             table_form = 1'b0;
  logic [2:0]       var_count = '0;
  logic [KEY_W-1:0] key_var0 = '0, key_var1 = '0, key_var2 = '0, key_var3 = '0;
  logic [TT_W-1:0]  truth_table = '0;
  logic [LIT_W-1:0] literal_in = '0;
  logic             out_stall = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [7:0]       cfg_max_keys = '0;

  logic             in_stall, out_valid, cfg_ready;
  logic [1:0]       status;
  logic [LIT_W-1:0] literal_out;

  gate_truth_table_hash_map_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .table_form_i  (table_form),
    .var_count_i   (var_count),
    .key_var0_i    (key_var0),
    .key_var1_i    (key_var1),
    .key_var2_i    (key_var2),
    .key_var3_i    (key_var3),
    .truth_table_i (truth_table),
    .literal_in_i  (literal_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .literal_out_o (literal_out),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_max_keys_i(cfg_max_keys)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow table state
  logic             sh_used [TABLE_SIZE];
  logic [KEY_W-1:0] sh_key  [TABLE_SIZE][4];
  int unsigned      sh_npairs [TABLE_SIZE];
  logic [TT_W-1:0]  sh_ptt  [TABLE_SIZE*PAIRS_PER_KEY];
  logic [LIT_W-1:0] sh_plit [TABLE_SIZE*PAIRS_PER_KEY];
  int unsigned      sh_keys;
  int unsigned      sh_max_keys;

  gate_item_t   pending_items[$];
  gate_answer_t expected_answers[$];
  int           mismatches = 0;
  int unsigned  cycles = 0;
  bit           calm = 1'b0;

  // Key pool for reuse in random phases
  gate_item_t   key_pool[$];
  logic [TT_W-1:0] tt_pool[8];

  function automatic logic [31:0] key_hash(logic [KEY_W-1:0] k[4]);
    logic [31:0] h;
    h = HASH_SEED;
    for (int i = 0; i < 4; i++) begin
      h = h + {11'd0, k[i]};
      h = h + (h << 10);
      h = h ^ (h >> 6);
    end
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // Canonical 16-bit table of an item
  function automatic logic [TT_W-1:0] canon_table(gate_item_t it);
    logic [TT_W-1:0] t;
    int n, row;
    t = '0;
    if (!it.form) begin
      for (int b = 0; b < 8; b++) begin
        t[2*b]   = it.tt[b];
        t[2*b+1] = it.tt[b];
      end
    end else begin
      n = (it.nv > 4) ? 4 : it.nv;
      for (int j = 0; j < 16; j++) begin
        row = 0;
        for (int k = 0; k < n; k++) row |= ((j >> (3 - k)) & 1) << k;
        t[j] = it.tt[row];
      end
    end
    return t;
  endfunction

  // Apply one item to the shadow table and return the answer
  function automatic gate_answer_t lookup_gate(gate_item_t it);
    gate_answer_t     a;
    logic [KEY_W-1:0] k[4];
    logic [TT_W-1:0]  t, tn;
    int n, s, base;
    bit found, empty;
    a.st = ST_MISS;
    a.lit = '0;
    found = 0;
    empty = 0;
    if (it.op == OP_NONE) return a;
    if (it.op == OP_CLEAR) begin
      foreach (sh_used[i]) sh_used[i] = 1'b0;
      sh_keys = 0;
      a.st = ST_HIT;
      return a;
    end
    k[0] = it.k0; k[1] = it.k1; k[2] = it.k2; k[3] = it.k3;
    if (!it.form) k[3] = NO_VAR;
    else begin
      n = (it.nv > 4) ? 4 : it.nv;
      for (int i = n; i < 4; i++) k[i] = NO_VAR;
    end
    t = canon_table(it);
    tn = ~t;
    s = key_hash(k) % TABLE_SIZE;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (!sh_used[s]) begin
        empty = 1;
        break;
      end
      if (sh_key[s][0] == k[0] && sh_key[s][1] == k[1] &&
          sh_key[s][2] == k[2] && sh_key[s][3] == k[3]) begin
        found = 1;
        break;
      end
      s = (s + 1) % TABLE_SIZE;
    end
    if (found) begin
      base = s * PAIRS_PER_KEY;
      n = sh_npairs[s];
      for (int p = 0; p < n; p++) begin
        if (sh_ptt[base+p] == t) begin
          a.st = ST_HIT;
          a.lit = sh_plit[base+p];
          return a;
        end
        if (sh_ptt[base+p] == tn) begin
          a.st = ST_HIT;
          a.lit = sh_plit[base+p] ^ LIT_W'(1);
          return a;
        end
      end
      if (it.op == OP_FIND) return a;
      if (n >= PAIRS_PER_KEY) begin
        a.st = ST_FULL;
        return a;
      end
      sh_ptt[base+n] = t;
      sh_plit[base+n] = it.lit;
      sh_npairs[s] = n + 1;
      a.st = ST_INSERTED;
      a.lit = it.lit;
      return a;
    end
    if (it.op == OP_FIND) return a;
    if (!empty || sh_keys >= sh_max_keys || sh_keys >= TABLE_SIZE - 1) begin
      a.st = ST_FULL;
      return a;
    end
    sh_used[s] = 1'b1;
    for (int i = 0; i < 4; i++) sh_key[s][i] = k[i];
    base = s * PAIRS_PER_KEY;
    sh_ptt[base] = t;
    sh_plit[base] = it.lit;
    sh_npairs[s] = 1;
    sh_keys++;
    a.st = ST_INSERTED;
    a.lit = it.lit;
    return a;
  endfunction

  // Input driver: predicts on acceptance, then presents the next item
  always @(posedge clk_i) begin
    gate_item_t nxt;
    bit load;
    if (rst_ni) begin
      cycles <= cycles + 1;
      load = !in_valid;
      if (in_valid && !in_stall) begin
        expected_answers.push_back(lookup_gate('{op_e'(opcode), table_form, var_count,
            key_var0, key_var1, key_var2, key_var3, truth_table, literal_in}));
        load = 1;
      end
      if (load) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
          nxt = pending_items.pop_front();
          opcode      <= nxt.op;
          table_form  <= nxt.form;
          var_count   <= nxt.nv;
          key_var0    <= nxt.k0;
          key_var1    <= nxt.k1;
          key_var2    <= nxt.k2;
          key_var3    <= nxt.k3;
          truth_table <= nxt.tt;
          literal_in  <= nxt.lit;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (cycles >= CYCLE_LIMIT) begin
        $display("FAIL gate_truth_table_hash_map_top");
        $finish;
      end
    end
  end

  // Result monitor with random output stalls
  always @(posedge clk_i) begin
    gate_answer_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d literal %0h", status, literal_out);
        end else begin
          e = expected_answers.pop_front();
          if (status !== e.st || literal_out !== e.lit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d literal %0h, got status %0d literal %0h",
                       e.st, e.lit, status, literal_out);
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 19);
    end
  end

  function automatic gate_item_t mk(op_e op, logic form, logic [2:0] nv,
                                    logic [KEY_W-1:0] k0, logic [KEY_W-1:0] k1,
                                    logic [KEY_W-1:0] k2, logic [KEY_W-1:0] k3,
                                    logic [TT_W-1:0] tt, logic [LIT_W-1:0] lit);
    gate_item_t it;
    it = '{op, form, nv, k0, k1, k2, k3, tt, lit};
    return it;
  endfunction

  function automatic logic [KEY_W-1:0] rand_var();
    return ($urandom_range(9) == 0) ? NO_VAR : KEY_W'($urandom_range(1048575));
  endfunction

  // Random item: mostly gets and finds over a reused key pool
  function automatic gate_item_t rand_item();
    gate_item_t it;
    int r;
    r = $urandom_range(99);
    if (key_pool.size() == 0 || $urandom_range(99) < 55) begin
      it = mk(OP_GET, 1'($urandom_range(1)), 3'($urandom_range(7)), rand_var(),
              rand_var(), rand_var(), rand_var(), '0, '0);
      key_pool.push_back(it);
    end else begin
      it = key_pool[$urandom_range(key_pool.size() - 1)];
    end
    it.op = (r < 35) ? OP_FIND : (r < 95) ? OP_GET : (r < 97) ? OP_NONE : OP_CLEAR;
    it.tt = ($urandom_range(3) == 0) ? TT_W'($urandom) : tt_pool[$urandom_range(7)];
    if ($urandom_range(2) == 0) it.tt = ~it.tt;
    it.lit = LIT_W'($urandom);
    return it;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() > 0 || in_valid || expected_answers.size() > 0);
  endtask

  // Write max_keys while the block is idle
  task automatic set_max_keys(logic [7:0] v);
    wait_idle();
    repeat (20) @(posedge clk_i);
    cfg_valid    <= 1'b1;
    cfg_max_keys <= v;
    do @(posedge clk_i); while (!cfg_ready);
    sh_max_keys = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    foreach (sh_used[i]) sh_used[i] = 1'b0;
    sh_keys = 0;
    sh_max_keys = MAX_KEYS_RST;
    foreach (tt_pool[i]) tt_pool[i] = TT_W'($urandom);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty find, insert, plain and complement hits, forms, extremes
    calm = 1'b1;
    pending_items.push_back(mk(OP_FIND, 0, 0, 0, 0, 0, 0, 16'h00ff, 0));
    pending_items.push_back(mk(OP_GET, 0, 0, 0, 0, 0, NO_VAR, 16'hff5a, 21'h1fffff));
    pending_items.push_back(mk(OP_FIND, 0, 0, 0, 0, 0, 21'h12345, 16'h005a, 0));
    pending_items.push_back(mk(OP_FIND, 0, 0, 0, 0, 0, 0, 16'h00a5, 0));
    pending_items.push_back(mk(OP_GET, 1, 3'd7, NO_VAR, NO_VAR, NO_VAR, NO_VAR,
                               16'hffff, 21'h0));
    pending_items.push_back(mk(OP_FIND, 1, 3'd4, NO_VAR, NO_VAR, NO_VAR, NO_VAR, 16'h0, 0));
    pending_items.push_back(mk(OP_GET, 1, 3'd0, 21'hfffff, 21'hfffff, 21'hfffff, 21'hfffff,
                               16'h0001, 21'h00abc));
    pending_items.push_back(mk(OP_GET, 1, 3'd1, 21'h1, 21'h2, 21'h3, 21'h4, 16'hfffe, 21'h5));
    pending_items.push_back(mk(OP_GET, 1, 3'd2, 21'h1, 21'h2, 21'h3, 21'h4, 16'h1234, 21'h7));
    pending_items.push_back(mk(OP_GET, 1, 3'd3, 21'h1, 21'h2, 21'h3, 21'h4, 16'hbeef, 21'h9));
    pending_items.push_back(mk(OP_FIND, 1, 3'd3, 21'h1, 21'h2, 21'h3, 21'h0, 16'h00ef, 0));
    pending_items.push_back(mk(OP_NONE, 1, 3'd4, 21'h1, 21'h2, 21'h3, 21'h4, 16'h0, 21'h3));
    // Pair list overflow on one key
    for (int i = 0; i < 9; i++)
      pending_items.push_back(mk(OP_GET, 0, 0, 21'h77, 21'h88, 21'h99, 0,
                                 16'(i * 3 + 1), 21'(100 + i)));
    pending_items.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_FIND, 0, 0, 21'h77, 21'h88, 21'h99, 0, 16'h1, 0));

    // Smallest key limit
    set_max_keys(8'd1);
    pending_items.push_back(mk(OP_GET, 0, 0, 21'h10, 21'h11, 21'h12, 0, 16'h0f, 21'h20));
    pending_items.push_back(mk(OP_GET, 0, 0, 21'h13, 21'h11, 21'h12, 0, 16'h0f, 21'h22));
    pending_items.push_back(mk(OP_GET, 0, 0, 21'h10, 21'h11, 21'h12, 0, 16'h3c, 21'h24));
    calm = 1'b0;
    for (int i = 0; i < 40; i++) pending_items.push_back(rand_item());

    // Largest key limit: fill the table toward its hard limit
    set_max_keys(8'd255);
    pending_items.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 380; i++) begin
      gate_item_t it;
      it = rand_item();
      if (it.op == OP_CLEAR) it.op = OP_GET;
      pending_items.push_back(it);
    end

    // Middle limit, fresh table
    set_max_keys(8'($urandom_range(20, 200)));
    pending_items.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 200; i++) pending_items.push_back(rand_item());

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("PASS gate_truth_table_hash_map_top");
    end else begin
      $display("FAIL gate_truth_table_hash_map_top");
    end
    $finish;
  end

endmodule

FILE: gate_truth_table_hash_map_top.f
hdl/gtthm_pkg.sv
hdl/gtthm_ram.sv
hdl/gtthm_ctrl.sv
hdl/gtthm_dpath.sv
hdl/gate_truth_table_hash_map_top.sv
tb/sv/gate_truth_table_hash_map_top_tb.sv
